[rtl/core/sha256_pkg.sv]
// SHA-256 package: constants, round table, sequencer state type and helpers.
// No dependencies.
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } seq_state_t;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LEN_OFFSET  = 6'd56;
    localparam int         ROUNDS      = 64;

    typedef struct packed {
        logic start;
        logic load;
    } rnd_ctl_t;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [0:63];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[i];
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] h [0:7];
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return h[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

[rtl/core/sha256_byte_stream_hasher_core.sv]
// SHA-256 byte stream hasher top level: byte intake, padding sequencer, digest output.
// Depends on sha256_pkg and sha256_round.
// Bytes are accepted one per cycle while idle; each full block then runs its rounds
// and the add step in the shared round unit. At end of message pad bytes go in one
// per cycle, then 8 digest words. Input is held off while the single round unit works.
// Reset is asynchronous active low: initial hash values, zero counts, no output.
module sha256_byte_stream_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_tlast    // last_word
);
    import sha256_pkg::*;

    seq_state_t   state_reg, state_next;
    logic [31:0]  h_reg [0:7];
    logic [31:0]  buf_reg [0:15];
    logic [5:0]   fill_reg;
    logic [63:0]  cnt_reg;
    logic [5:0]   rnd_reg;
    logic         fin_reg;
    logic         len_done_reg;
    logic         pad_first_reg;
    logic [2:0]   oi_reg;
    logic [63:0]  bits_w;
    logic [7:0]   pb;
    logic         push, blk_full, acc, emit_done;
    rnd_ctl_t     ctl;
    logic [255:0] hash_vec, work;

    assign acc       = s_tvalid && s_tready;
    assign s_tready  = state_reg == ST_IDLE;
    assign bits_w    = {cnt_reg[60:0], 3'b000};
    assign blk_full  = fill_reg == 6'd63;
    assign emit_done = state_reg == ST_EMIT && m_tready && oi_reg == 3'd7;

    always_comb
    begin
        pb = 8'h00;
        push = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pb = s_tdata;
                push = acc && s_tuser;
            end
            ST_PAD:
            begin
                pb = pad_first_reg ? PAD_BYTE : 8'h00;
                push = 1'b1;
            end
            ST_LEN:
            begin
                pb = bits_w[63 - 8*fill_reg[2:0] -: 8];
                push = 1'b1;
            end
            default:
            begin
                pb = 8'h00;
                push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            hash_vec[255 - 32*i -: 32] = h_reg[i];
        ctl.load  = push && blk_full;
        ctl.start = state_reg == ST_ROUND;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (acc)
                begin
                    if (s_tuser && blk_full)
                        state_next = ST_ROUND;
                    else if (s_tlast)
                        state_next = ST_PAD;
                end
            ST_PAD:
                if (blk_full)
                    state_next = ST_ROUND;
                else if (fill_reg == LEN_OFFSET - 6'd1)
                    state_next = ST_LEN;
            ST_LEN:
                if (blk_full)
                    state_next = ST_ROUND;
            ST_ROUND:
                if (rnd_reg == 6'(ROUNDS - 1))
                    state_next = ST_ADD;
            ST_ADD:
                if (!fin_reg)
                    state_next = ST_IDLE;
                else if (len_done_reg)
                    state_next = ST_EMIT;
                else
                    state_next = ST_PAD;
            ST_EMIT:
                if (m_tready && oi_reg == 3'd7)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    sha256_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .round_idx (rnd_reg),
        .msg_word  (buf_reg[rnd_reg[3:0]]),
        .hash_in   (hash_vec),
        .work_out  (work)
    );

    // len_done marks that the length bytes went into the block being compressed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            rnd_reg       <= '0;
            fin_reg       <= 1'b0;
            len_done_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            oi_reg        <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_hash(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            if (acc)
                fin_reg <= s_tlast;
            if (acc)
                len_done_reg <= 1'b0;
            else if (state_reg == ST_LEN && blk_full)
                len_done_reg <= 1'b1;
            if (acc)
                pad_first_reg <= s_tlast;
            else if (state_reg == ST_PAD)
                pad_first_reg <= 1'b0;
            if (emit_done)
                cnt_reg <= '0;
            else if (acc && s_tuser)
                cnt_reg <= cnt_reg + 64'd1;
            if (push)
                fill_reg <= fill_reg + 6'd1;
            if (state_reg == ST_ROUND)
                rnd_reg <= rnd_reg + 6'd1;
            if (state_reg == ST_EMIT && m_tready)
                oi_reg <= oi_reg + 3'd1;
            if (state_reg == ST_ADD)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + work[255 - 32*i -: 32];
            end
            else if (emit_done)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= init_hash(3'(i));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[fill_reg[5:2]][31 - 8*fill_reg[1:0] -: 8] <= pb;
    end

    assign m_tvalid = state_reg == ST_EMIT;
    assign m_tdata  = {5'd0, oi_reg, h_reg[oi_reg]};
    assign m_tlast  = oi_reg == 3'd7;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("accept during emit");
    a_round_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> (rnd_reg == 6'd0)) else $error("round count");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (state_reg == ST_IDLE))
        else $error("emit end");
`endif

endmodule

[rtl/core/sha256_round.sv]
// SHA-256 round unit: working variables, 16-word schedule window, one round per cycle while ctl.start is high.
// Depends on sha256_pkg.
module sha256_round (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha256_pkg::rnd_ctl_t ctl,
    input  logic [5:0]           round_idx,
    input  logic [31:0]          msg_word,
    input  logic [255:0]         hash_in,
    output logic [255:0]         work_out
);
    import sha256_pkg::*;

    logic [31:0] r_reg [0:7];
    logic [31:0] w_reg [0:15];
    logic [31:0] w_cur, s0, s1, w_new, t1, t2, e, a;

    assign s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + s0 + w_reg[9] + s1;
    assign w_cur = round_idx[5:4] == 2'd0 ? msg_word : w_new;
    assign e = r_reg[4];
    assign a = r_reg[0];
    assign t1 = r_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & r_reg[5]) ^ (~e & r_reg[6])) + round_k(round_idx) + w_cur;
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & r_reg[1]) ^ (a & r_reg[2]) ^ (r_reg[1] & r_reg[2]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                r_reg[i] <= '0;
            for (int i = 0; i < 16; i++)
                w_reg[i] <= '0;
        end
        else if (ctl.load)
        begin
            for (int i = 0; i < 8; i++)
                r_reg[i] <= hash_in[255 - 32*i -: 32];
        end
        else if (ctl.start)
        begin
            r_reg[7] <= r_reg[6];
            r_reg[6] <= r_reg[5];
            r_reg[5] <= e;
            r_reg[4] <= r_reg[3] + t1;
            r_reg[3] <= r_reg[2];
            r_reg[2] <= r_reg[1];
            r_reg[1] <= a;
            r_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_cur;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            work_out[255 - 32*i -: 32] = r_reg[i];
    end

endmodule
